[hw/rtl/ppsep_pkg.sv]
// ----------------------------------------------------------------------------
// ppsep_pkg
// Types and constants shared by the pair separation pipeline.
// ----------------------------------------------------------------------------
package ppsep_pkg;

   localparam int CoordWidth = 32;
   localparam int BoxWidth   = 31;
   localparam int MagWidth   = 33;
   localparam int SumWidth   = 66;
   localparam int RootWidth  = 33;
   localparam int QuotWidth  = 31;

   localparam logic [1:0] CSR_BOX_X = 2'd0;
   localparam logic [1:0] CSR_BOX_Y = 2'd1;
   localparam logic [1:0] CSR_BOX_Z = 2'd2;

   localparam logic [QuotWidth-1:0] COS_ONE = QuotWidth'(1) << 30;

   typedef struct packed {
      logic signed [CoordWidth-1:0] first_x;
      logic signed [CoordWidth-1:0] first_y;
      logic signed [CoordWidth-1:0] first_z;
      logic signed [CoordWidth-1:0] second_x;
      logic signed [CoordWidth-1:0] second_y;
      logic signed [CoordWidth-1:0] second_z;
   } req_type;

   typedef struct packed {
      logic        [31:0] separation_distance;
      logic signed [31:0] cos_polar;
      logic               coincident;
   } rsp_type;

   // per-transaction sideband carried alongside the sqrt and divide stages
   typedef struct packed {
      logic                neg;
      logic                zero;
      logic [MagWidth-1:0] mz;
   } side_type;

endpackage

[hw/rtl/ppsep_front.sv]
// ----------------------------------------------------------------------------
// ppsep_front
// Raw separation, minimum image shift, squares and sum of squares.
// ----------------------------------------------------------------------------
module ppsep_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  ppsep_pkg::req_type              in_data,
   input  logic [ppsep_pkg::BoxWidth-1:0]  box_x,
   input  logic [ppsep_pkg::BoxWidth-1:0]  box_y,
   input  logic [ppsep_pkg::BoxWidth-1:0]  box_z,
   output logic                            out_valid,
   output logic [ppsep_pkg::SumWidth-1:0]  out_sum,
   output ppsep_pkg::side_type             out_side
);
   import ppsep_pkg::*;

   function automatic logic [MagWidth:0] min_image(input logic signed [32:0] d,
                                                   input logic [BoxWidth-1:0] l);
      logic signed [33:0] de;
      logic signed [33:0] dm;
      logic signed [33:0] dp;
      logic signed [33:0] r;
      logic [33:0] m;
      logic [33:0] mm;
      logic [33:0] mp;
      logic [33:0] mr;
      de = {d[32], d};
      dm = de - $signed({3'b000, l});
      dp = de + $signed({3'b000, l});
      m  = de[33] ? 34'(-de) : 34'(de);
      mm = dm[33] ? 34'(-dm) : 34'(dm);
      mp = dp[33] ? 34'(-dp) : 34'(dp);
      if (mm < m)      r = dm;
      else if (mp < m) r = dp;
      else             r = de;
      mr = r[33] ? 34'(-r) : 34'(r);
      return {r[33], mr[MagWidth-1:0]};
   endfunction

   logic signed [32:0] dx_ff, dy_ff, dz_ff;
   logic [MagWidth-1:0] mx_ff, my_ff, mz1_ff, mz2_ff, mz3_ff;
   logic neg1_ff, neg2_ff, neg3_ff;
   logic [SumWidth-1:0] sqx_ff, sqy_ff, sqz_ff, sum_ff;
   logic zero_ff;
   logic [3:0] valid_ff;
   logic [MagWidth:0] ix_in, iy_in, iz_in;
   logic [SumWidth-1:0] sum_in;

   assign ix_in  = min_image(dx_ff, box_x);
   assign iy_in  = min_image(dy_ff, box_y);
   assign iz_in  = min_image(dz_ff, box_z);
   assign sum_in = sqx_ff + sqy_ff + sqz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff   <= 33'(in_data.first_x) - 33'(in_data.second_x);
         dy_ff   <= 33'(in_data.first_y) - 33'(in_data.second_y);
         dz_ff   <= 33'(in_data.first_z) - 33'(in_data.second_z);
         mx_ff   <= ix_in[MagWidth-1:0];
         my_ff   <= iy_in[MagWidth-1:0];
         mz1_ff  <= iz_in[MagWidth-1:0];
         neg1_ff <= iz_in[MagWidth];
         sqx_ff  <= SumWidth'(mx_ff) * SumWidth'(mx_ff);
         sqy_ff  <= SumWidth'(my_ff) * SumWidth'(my_ff);
         sqz_ff  <= SumWidth'(mz1_ff) * SumWidth'(mz1_ff);
         mz2_ff  <= mz1_ff;
         neg2_ff <= neg1_ff;
         sum_ff  <= sum_in;
         zero_ff <= (sum_in == '0);
         mz3_ff  <= mz2_ff;
         neg3_ff <= neg2_ff;
      end
   end

   assign out_valid     = valid_ff[3];
   assign out_sum       = sum_ff;
   assign out_side.neg  = neg3_ff;
   assign out_side.zero = zero_ff;
   assign out_side.mz   = mz3_ff;

endmodule

[hw/rtl/ppsep_sqrt.sv]
// ----------------------------------------------------------------------------
// ppsep_sqrt
// Pipelined restoring square root, one root bit per stage.
// ----------------------------------------------------------------------------
module ppsep_sqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic [ppsep_pkg::SumWidth-1:0]  in_sum,
   input  ppsep_pkg::side_type             in_side,
   output logic                            out_valid,
   output logic [ppsep_pkg::RootWidth-1:0] out_root,
   output ppsep_pkg::side_type             out_side
);
   import ppsep_pkg::*;

   localparam int Stages = RootWidth;

   logic [35:0]           rem_ff  [Stages];
   logic [RootWidth-1:0]  root_ff [Stages];
   logic [SumWidth-1:0]   src_ff  [Stages];
   side_type              side_ff [Stages];
   logic [Stages-1:0]     valid_ff;

   for (genvar k = 0; k < Stages; k++) begin : g_stage
      logic [35:0]          rem_p;
      logic [RootWidth-1:0] root_p;
      logic [SumWidth-1:0]  src_p;
      side_type             side_p;
      logic                 valid_p;
      logic [35:0]          rem_t;
      logic [35:0]          trial;
      logic                 take;

      if (k == 0) begin : g_first
         assign rem_p   = '0;
         assign root_p  = '0;
         assign src_p   = in_sum;
         assign side_p  = in_side;
         assign valid_p = in_valid;
      end else begin : g_next
         assign rem_p   = rem_ff[k-1];
         assign root_p  = root_ff[k-1];
         assign src_p   = src_ff[k-1];
         assign side_p  = side_ff[k-1];
         assign valid_p = valid_ff[k-1];
      end

      assign rem_t = {rem_p[33:0], src_p[SumWidth-1 -: 2]};
      assign trial = {1'b0, root_p, 2'b01};
      assign take  = (rem_t >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= take ? rem_t - trial : rem_t;
            root_ff[k] <= {root_p[RootWidth-2:0], take};
            src_ff[k]  <= {src_p[SumWidth-3:0], 2'b00};
            side_ff[k] <= side_p;
         end
      end
   end

   assign out_valid = valid_ff[Stages-1];
   assign out_root  = root_ff[Stages-1];
   assign out_side  = side_ff[Stages-1];

endmodule

[hw/rtl/ppsep_div.sv]
// ----------------------------------------------------------------------------
// ppsep_div
// Rounded quotient |dz| * 2^30 / root, pipelined, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ppsep_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic [ppsep_pkg::RootWidth-1:0] in_root,
   input  ppsep_pkg::side_type             in_side,
   output logic                            out_valid,
   output logic [ppsep_pkg::QuotWidth-1:0] out_quot,
   output logic [ppsep_pkg::RootWidth-1:0] out_root,
   output ppsep_pkg::side_type             out_side
);
   import ppsep_pkg::*;

   localparam int Stages = QuotWidth;
   localparam int NumWidth = 63;

   // numerator is below root * 2^31, so the top bits start under the divisor
   logic [NumWidth-1:0]  num_ff;
   logic [RootWidth-1:0] root0_ff;
   side_type             side0_ff;
   logic                 valid0_ff;

   logic [RootWidth:0]   rem_ff  [Stages];
   logic [QuotWidth-1:0] quot_ff [Stages];
   logic [QuotWidth-1:0] src_ff  [Stages];
   logic [RootWidth-1:0] root_ff [Stages];
   side_type             side_ff [Stages];
   logic [Stages-1:0]    valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else if (en) begin
         valid0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff   <= (NumWidth'(in_side.mz) << 30) + NumWidth'(in_root >> 1);
         root0_ff <= in_root;
         side0_ff <= in_side;
      end
   end

   for (genvar k = 0; k < Stages; k++) begin : g_stage
      logic [RootWidth:0]   rem_p;
      logic [QuotWidth-1:0] quot_p;
      logic [QuotWidth-1:0] src_p;
      logic [RootWidth-1:0] root_p;
      side_type             side_p;
      logic                 valid_p;
      logic [RootWidth:0]   rem_t;
      logic                 take;

      if (k == 0) begin : g_first
         assign rem_p   = (RootWidth+1)'(num_ff[NumWidth-1:QuotWidth]);
         assign quot_p  = '0;
         assign src_p   = num_ff[QuotWidth-1:0];
         assign root_p  = root0_ff;
         assign side_p  = side0_ff;
         assign valid_p = valid0_ff;
      end else begin : g_next
         assign rem_p   = rem_ff[k-1];
         assign quot_p  = quot_ff[k-1];
         assign src_p   = src_ff[k-1];
         assign root_p  = root_ff[k-1];
         assign side_p  = side_ff[k-1];
         assign valid_p = valid_ff[k-1];
      end

      assign rem_t = {rem_p[RootWidth-1:0], src_p[QuotWidth-1]};
      assign take  = (rem_t >= {1'b0, root_p});

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= take ? rem_t - {1'b0, root_p} : rem_t;
            quot_ff[k] <= {quot_p[QuotWidth-2:0], take};
            src_ff[k]  <= {src_p[QuotWidth-2:0], 1'b0};
            root_ff[k] <= root_p;
            side_ff[k] <= side_p;
         end
      end
   end

   assign out_valid = valid_ff[Stages-1];
   assign out_quot  = quot_ff[Stages-1];
   assign out_root  = root_ff[Stages-1];
   assign out_side  = side_ff[Stages-1];

endmodule

[hw/rtl/periodic_pair_separation_core.sv]
// ----------------------------------------------------------------------------
// periodic_pair_separation_core
// Minimum image separation distance and polar cosine of a particle pair.
//
//   channel | direction | handshake          | payload
//   req_    | in        | valid / stall      | ppsep_pkg::req_type
//   rsp_    | out       | valid / stall      | ppsep_pkg::rsp_type
//   csr_    | in        | valid / ready      | index, box length
//
// One transaction per cycle unless a valid response is stalled; the pipeline
// is four front stages, 33 square root stages (one root bit each), a numerator
// register, 31 divide stages (one quotient bit each) and the output register.
// Synchronous reset clears the pipeline valid bits and sets every box length
// to 1.0. An output stall on a valid response freezes the whole pipeline and stalls req_.
// ----------------------------------------------------------------------------
module periodic_pair_separation_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  ppsep_pkg::req_type             req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output ppsep_pkg::rsp_type             rsp_payload,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [1:0]                     csr_index,
   input  logic [ppsep_pkg::BoxWidth-1:0] csr_wdata
);
   import ppsep_pkg::*;

   logic [BoxWidth-1:0] box_x_ff, box_y_ff, box_z_ff;
   logic en;

   logic                 f_valid;
   logic [SumWidth-1:0]  f_sum;
   side_type             f_side;
   logic                 s_valid;
   logic [RootWidth-1:0] s_root;
   side_type             s_side;
   logic                 d_valid;
   logic [QuotWidth-1:0] d_quot;
   logic [RootWidth-1:0] d_root;
   side_type             d_side;

   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;
   logic [QuotWidth-1:0] cos_mag;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_ff <= BoxWidth'(65536);
         box_y_ff <= BoxWidth'(65536);
         box_z_ff <= BoxWidth'(65536);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BOX_X: box_x_ff <= csr_wdata;
            CSR_BOX_Y: box_y_ff <= csr_wdata;
            CSR_BOX_Z: box_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   ppsep_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_payload),
      .box_x     (box_x_ff),
      .box_y     (box_y_ff),
      .box_z     (box_z_ff),
      .out_valid (f_valid),
      .out_sum   (f_sum),
      .out_side  (f_side)
   );

   ppsep_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_sum    (f_sum),
      .in_side   (f_side),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_side  (s_side)
   );

   ppsep_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .in_root   (s_root),
      .in_side   (s_side),
      .out_valid (d_valid),
      .out_quot  (d_quot),
      .out_root  (d_root),
      .out_side  (d_side)
   );

   always_comb begin
      cos_mag = (d_quot > COS_ONE) ? COS_ONE : d_quot;
      rsp_in.separation_distance = d_root[RootWidth-1] ? 32'hFFFF_FFFF
                                                       : d_root[31:0];
      rsp_in.coincident = d_side.zero;
      if (d_side.zero) begin
         rsp_in.cos_polar = '0;
      end else if (d_side.neg) begin
         rsp_in.cos_polar = -$signed(32'(cos_mag));
      end else begin
         rsp_in.cos_polar = $signed(32'(cos_mag));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[hw/rtl/ppsep_checker.sv]
// ----------------------------------------------------------------------------
// ppsep_checker
// Port level checks for the pair separation core.
// ----------------------------------------------------------------------------
module ppsep_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input ppsep_pkg::rsp_type rsp_payload
);
   import ppsep_pkg::*;

   a_coincident_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.coincident |->
         rsp_payload.cos_polar == 0 && rsp_payload.separation_distance == 0)
      else $error("coincident transaction with non-zero result");

   a_cos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.cos_polar <= 32'sh4000_0000 &&
                    rsp_payload.cos_polar >= -32'sh4000_0000)
      else $error("cosine outside unit range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without output back-pressure");

   a_no_req_bubble_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !rsp_valid |-> !req_stall)
      else $error("request stalled while output empty");

endmodule

bind periodic_pair_separation_core ppsep_checker u_ppsep_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

[verif/tb_periodic_pair_separation_core.sv]
// ----------------------------------------------------------------------------
// tb_periodic_pair_separation_core
// Self-checking bench for the minimum image pair separation pipeline.
// A directed table, then random bursts of pairs, are checked against fixed
// results or a predictor of distance, polar cosine and coincidence. Box lengths are
// rewritten between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_periodic_pair_separation_core;
   import ppsep_pkg::*;

   localparam int Latency    = 70;
   localparam int CycleLimit = 400000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_payload = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_payload;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = '0;
   logic [BoxWidth-1:0] csr_wdata = '0;

   periodic_pair_separation_core DUT (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   logic [BoxWidth-1:0] box_len [3];
   rsp_type expected_rsps [$];
   int      mismatches = 0;
   int      cycles = 0;
   bit      hold_long = 1'b0;
   bit      use_burst = 1'b0;

   typedef struct {
      req_type req;
      bit      known;
      rsp_type rsp;
   } row_type;
   row_type rows [$];

   function automatic logic signed [35:0] wrap_axis(logic signed [CoordWidth-1:0] a,
                                                     logic signed [CoordWidth-1:0] b,
                                                     logic [BoxWidth-1:0] box);
      logic signed [35:0] d, l, m, dm, dp;
      d  = 36'(a) - 36'(b);
      l  = 36'(signed'({1'b0, box}));
      m  = d < 0 ? -d : d;
      dm = (d - l) < 0 ? -(d - l) : (d - l);
      dp = (d + l) < 0 ? -(d + l) : (d + l);
      if (dm < m) return d - l;
      if (dp < m) return d + l;
      return d;
   endfunction

   function automatic rsp_type separation_of(req_type r);
      logic signed [35:0] dx, dy, dz;
      logic [MagWidth-1:0] mx, my, mz;
      logic [SumWidth-1:0] s;
      logic [RootWidth+1:0] root, trial;
      logic [63:0] num, c;
      rsp_type o;
      dx = wrap_axis(r.first_x, r.second_x, box_len[0]);
      dy = wrap_axis(r.first_y, r.second_y, box_len[1]);
      dz = wrap_axis(r.first_z, r.second_z, box_len[2]);
      mx = MagWidth'(dx < 0 ? -dx : dx);
      my = MagWidth'(dy < 0 ? -dy : dy);
      mz = MagWidth'(dz < 0 ? -dz : dz);
      s  = SumWidth'(mx) * mx + SumWidth'(my) * my + SumWidth'(mz) * mz;
      root = '0;
      for (int b = RootWidth; b >= 0; b--) begin
         trial = root | (35'(1) << b);
         if ((70'(trial) * trial) <= 70'(s)) root = trial;
      end
      o.coincident = (s == 0);
      o.separation_distance = root > 35'hFFFFFFFF ? 32'hFFFFFFFF : root[31:0];
      o.cos_polar = '0;
      if (s != 0) begin
         num = 64'(mz) << 30;
         c = (num + 64'(root / 2)) / 64'(root);
         if (c > (64'd1 << 30)) c = 64'd1 << 30;
         o.cos_polar = dz < 0 ? -32'(c) : 32'(c);
      end
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_payload.separation_distance,
                            32'd0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_payload.separation_distance !== want.separation_distance)
               report_mismatch("distance", rsp_payload.separation_distance,
                               want.separation_distance);
            if (rsp_payload.cos_polar !== want.cos_polar)
               report_mismatch("cos_polar", rsp_payload.cos_polar, want.cos_polar);
            if (rsp_payload.coincident !== want.coincident)
               report_mismatch("coincident", 32'(rsp_payload.coincident),
                               32'(want.coincident));
         end
      end
   end

   // receiver stall pattern, with one long hold-off on request
   always @(posedge clock) begin
      int n;
      if (hold_long) begin
         rsp_stall <= 1'b1;
         for (n = 0; n < 300; n++) @(posedge clock);
         rsp_stall <= 1'b0;
         hold_long = 1'b0;
      end else if (use_burst) begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // valid stays high after acceptance; the caller drops it before a gap
   task automatic send_pair(req_type r, bit known, rsp_type want);
      req_valid   <= 1'b1;
      req_payload <= r;
      expected_rsps.push_back(known ? want : separation_of(r));
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (Latency + 10) @(posedge clock);
   endtask

   task automatic write_box(logic [1:0] idx, logic [BoxWidth-1:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      box_len[idx] = v;
   endtask

   task automatic write_boxes(logic [BoxWidth-1:0] x, y, z);
      write_box(CSR_BOX_X, x);
      write_box(CSR_BOX_Y, y);
      write_box(CSR_BOX_Z, z);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] rand_coord(int kind);
      case (kind)
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
         2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         default: return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
      endcase
   endfunction

   task automatic random_phase(int count);
      req_type r;
      int kind, gap, burst;
      while (count > 0) begin
         burst = $urandom_range(1, 20);
         for (int i = 0; i < burst && count > 0; i++) begin
            kind = $urandom_range(0, 3);
            r.first_x  = rand_coord(kind); r.second_x = rand_coord(kind);
            r.first_y  = rand_coord(kind); r.second_y = rand_coord(kind);
            r.first_z  = rand_coord(kind); r.second_z = rand_coord(kind);
            if ($urandom_range(0, 15) == 0) begin
               r.second_x = r.first_x; r.second_y = r.first_y; r.second_z = r.first_z;
            end
            send_pair(r, 1'b0, '0);
            count--;
         end
         gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
         if (gap > 0) idle(gap);
      end
   endtask

   function automatic req_type pair(logic [31:0] ax, ay, az, bx, by, bz);
      req_type r;
      r.first_x = ax; r.first_y = ay; r.first_z = az;
      r.second_x = bx; r.second_y = by; r.second_z = bz;
      return r;
   endfunction

   function automatic rsp_type result(logic [31:0] d, logic [31:0] c, logic z);
      rsp_type o;
      o.separation_distance = d; o.cos_polar = c; o.coincident = z;
      return o;
   endfunction

   initial begin
      box_len[0] = 31'd65536; box_len[1] = 31'd65536; box_len[2] = 31'd65536;
      rows.push_back('{pair(0, 0, 0, 0, 0, 0), 1'b1, result(0, 0, 1'b1)});
      rows.push_back('{pair(32'h80000000, 5, 32'h7FFFFFFF, 32'h80000000, 5, 32'h7FFFFFFF),
                       1'b1, result(0, 0, 1'b1)});
      rows.push_back('{pair(0, 0, 32'h4000, 0, 0, 0), 1'b1,
                       result(32'h4000, 32'h40000000, 1'b0)});
      rows.push_back('{pair(0, 0, 0, 0, 0, 32'h4000), 1'b1,
                       result(32'h4000, 32'hC0000000, 1'b0)});
      rows.push_back('{pair(32'h4000, 0, 0, 0, 0, 0), 1'b1, result(32'h4000, 0, 1'b0)});
      rows.push_back('{pair(32'hC000, 0, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{pair(32'h8000, 32'h8000, 32'h8000, 0, 0, 0), 1'b0, '0});
      rows.push_back('{pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                            32'h80000000, 32'h80000000, 32'h80000000), 1'b0, '0});
      rows.push_back('{pair(32'h80000000, 32'h80000000, 32'h80000000,
                            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF), 1'b0, '0});
      rows.push_back('{pair(32'h00050000, 0, 32'hFFFB0000, 0, 0, 0), 1'b0, '0});
      rows.push_back('{pair(32'hFFFFFFFF, 1, 32'h1, 0, 0, 0), 1'b0, '0});

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      use_burst = 1'b1;
      foreach (rows[i]) send_pair(rows[i].req, rows[i].known, rows[i].rsp);
      drain();

      write_boxes(31'h7FFFFFFF, 31'd1, 31'h7FFFFFFF);
      foreach (rows[i]) send_pair(rows[i].req, 1'b0, '0);
      random_phase(200);
      drain();

      write_boxes(31'd1 << 18, 31'd3 << 16, 31'd5 << 15);
      hold_long = 1'b1;
      random_phase(250);
      drain();

      write_boxes(31'($urandom()), 31'($urandom_range(1, 1 << 20)), 31'($urandom()));
      use_burst = 1'b0;
      random_phase(100);
      use_burst = 1'b1;
      random_phase(150);
      drain();

      write_boxes(31'd65536, 31'd65536, 31'd65536);
      random_phase(250);
      drain();

      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

[periodic_pair_separation_core.f]
hw/rtl/ppsep_pkg.sv
hw/rtl/ppsep_front.sv
hw/rtl/ppsep_sqrt.sv
hw/rtl/ppsep_div.sv
hw/rtl/periodic_pair_separation_core.sv
hw/rtl/ppsep_checker.sv
verif/tb_periodic_pair_separation_core.sv
